### sv/plin_pkg.sv
// Shared constants, codes and types for the piecewise linear interpolator.
`timescale 1ns / 1ps

package plin_pkg;

  // Default sizes
  localparam int DEF_MAX_POINTS  = 16;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_INDEX_WIDTH = $clog2(DEF_MAX_POINTS);

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

### sv/plin_if.sv
// Valid/ready channel interfaces for query/write beats and result beats.
`timescale 1ns / 1ps

interface plin_in_if #(
  parameter int VALUE_WIDTH = plin_pkg::DEF_VALUE_WIDTH,
  parameter int INDEX_WIDTH = plin_pkg::DEF_INDEX_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [INDEX_WIDTH-1:0]        point_index;
  logic signed [VALUE_WIDTH-1:0] x_value;
  logic signed [VALUE_WIDTH-1:0] y_value;

  modport source (output valid, operation, point_index, x_value, y_value, input ready);
  modport sink   (input valid, operation, point_index, x_value, y_value, output ready);
endinterface

interface plin_out_if #(
  parameter int VALUE_WIDTH = plin_pkg::DEF_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] interp_value;
  logic                          divide_fault;
  logic                          saturated;

  modport source (output valid, interp_value, divide_fault, saturated, input ready);
  modport sink   (input valid, interp_value, divide_fault, saturated, output ready);
endinterface

### sv/plin_table.sv
// Breakpoint storage: x and y memories, one write port, one registered read port.
`timescale 1ns / 1ps

module plin_table #(
  parameter int DEPTH = plin_pkg::DEF_MAX_POINTS,
  parameter int WIDTH = plin_pkg::DEF_VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic signed [WIDTH-1:0]    wr_x,
  input  logic signed [WIDTH-1:0]    wr_y,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [WIDTH-1:0]    rd_x,
  output logic signed [WIDTH-1:0]    rd_y
);
  import plin_pkg::*;

  logic signed [WIDTH-1:0] mem_x [DEPTH];
  logic signed [WIDTH-1:0] mem_y [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

### sv/plin_mul.sv
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module plin_mul #(
  parameter int WIDTH = plin_pkg::DEF_VALUE_WIDTH + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        mcand_in,
  input  logic [WIDTH-1:0]        mplier_in,
  output logic [2*WIDTH-1:0]      product,
  output plin_pkg::unit_status_t  status
);
  import plin_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [2*WIDTH-1:0] acc;
  logic [WIDTH-1:0]   mcand;
  logic [WIDTH-1:0]   mplier;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [WIDTH:0]     partial;

  // Add the multiplicand into the upper half when the current bit is set
  always_comb begin
    partial = {1'b0, acc[2*WIDTH-1:WIDTH]} + (mplier[0] ? {1'b0, mcand} : '0);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= mcand_in;
      mplier <= mplier_in;
    end else if (busy) begin
      acc    <= {partial, acc[WIDTH-1:1]};
      mplier <= mplier >> 1;
    end
  end

  assign product     = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### sv/plin_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, dividend MSB first.
`timescale 1ns / 1ps

module plin_div #(
  parameter int NUM_W = 2 * (plin_pkg::DEF_VALUE_WIDTH + 1),
  parameter int DEN_W = plin_pkg::DEF_VALUE_WIDTH + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUM_W-1:0]        dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic [NUM_W-1:0]        quotient,
  output plin_pkg::unit_status_t  status
);
  import plin_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quot;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;

  // One restoring step: bring down a bit, try the subtract
  always_comb begin
    shifted = {rem, num[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den};
    fits    = ~trial[DEN_W+1];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

  assign quotient    = quot;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### sv/piecewise_linear_interpolator.sv
// Top level: piecewise linear interpolation over a table of signed Q16.16 breakpoints.
//
// in_ch carries write and evaluate beats. A write beat (operation 0) stores
// (x_value, y_value) at point_index and gives no result. An evaluate beat
// (operation 1) gives one beat on out_ch: interp_value, divide_fault and
// saturated. cfg_wr_en/cfg_wr_data load point_count, which must be
// written only while the block is idle; the block itself does not enforce it.
// One evaluation at a time. The search reads the breakpoints from the
// table's single registered read port, then the multiplier step and then
// the divider step follow. A zero-width segment skips both units.
// in_ch.ready is high whenever no evaluation is in progress, so a write beat
// can be followed back to back by the next beat.
// The result sits in an output register; a write beat may be taken while it
// waits. If the receiver stalls, a following evaluation holds in its last
// step until the output register frees.
// Reset (rst, synchronous) sets point_count to 2 and clears the output valid.
// The breakpoint table is not cleared and must be written before use.
`timescale 1ns / 1ps

module piecewise_linear_interpolator #(
  parameter int MAX_POINTS  = plin_pkg::DEF_MAX_POINTS,
  parameter int VALUE_WIDTH = plin_pkg::DEF_VALUE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [$clog2(MAX_POINTS+1)-1:0]    cfg_wr_data,
  plin_in_if.sink                            in_ch,
  plin_out_if.source                         out_ch
);
  import plin_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int DW = VALUE_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int QW = VALUE_WIDTH + 2;
  localparam int RW = VALUE_WIDTH + 3;
  localparam logic [QW-1:0] QUO_SAT = (QW'(1) << VALUE_WIDTH) | QW'(1);
  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_FIRST    = 14'b00000000000010,
    S_LAST     = 14'b00000000000100,
    S_SCAN_RD  = 14'b00000000001000,
    S_SCAN_CMP = 14'b00000000010000,
    S_FETCH_A  = 14'b00000000100000,
    S_FETCH_B  = 14'b00000001000000,
    S_FETCH_C  = 14'b00000010000000,
    S_PREP     = 14'b00000100000000,
    S_MUL      = 14'b00001000000000,
    S_DIV      = 14'b00010000000000,
    S_CLAMP    = 14'b00100000000000,
    S_SUM      = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  state_t state;

  // Control registers
  logic [CW-1:0] point_count;
  logic          out_valid;

  // Datapath registers
  logic signed [VW-1:0] query;
  logic [IW-1:0]        last_idx;
  logic [IW-1:0]        seg;
  logic [IW-1:0]        k;
  logic signed [VW-1:0] xi;
  logic signed [VW-1:0] yi;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dq;
  logic [DW-1:0]        dx_mag;
  logic                 neg;
  logic [QW-1:0]        quo;
  logic signed [VW-1:0] res_val;
  logic                 res_fault;
  logic                 res_sat;
  logic signed [VW-1:0] out_val;
  logic                 out_fault;
  logic                 out_sat;

  // Combinational signals
  logic                 in_accept;
  logic                 tbl_wr_en;
  logic [IW-1:0]        rd_addr;
  logic signed [VW-1:0] rd_x;
  logic signed [VW-1:0] rd_y;
  logic [CW-1:0]        n_eff;
  logic [IW-1:0]        pen_idx;
  logic                 hit;
  logic [DW-1:0]        dy_mag;
  logic [DW-1:0]        dq_mag;
  logic [DW-1:0]        dx_mag_c;
  logic                 mul_start;
  logic                 div_start;
  logic [PW-1:0]        product;
  logic [PW-1:0]        quotient;
  unit_status_t         mul_stat;
  unit_status_t         div_stat;
  logic                 quo_over;
  logic [RW-1:0]        yi_ext;
  logic [RW-1:0]        quo_ext;
  logic [RW-1:0]        sum;
  logic                 sum_hi;
  logic                 sum_lo;
  logic                 out_load;

  // Handshake and table write
  assign in_ch.ready = (state == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign tbl_wr_en   = in_accept && (in_ch.operation == OP_WRITE) &&
                       ({1'b0, in_ch.point_index} < (IW+1)'(MAX_POINTS));
  assign out_load    = (state == S_OUT) && (!out_valid || out_ch.ready);

  // Effective count, clamped to at least 2 and at most the table depth
  always_comb begin
    if (point_count < CW'(2)) begin
      n_eff = CW'(2);
    end else if (point_count > CW'(MAX_POINTS)) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  assign pen_idx = last_idx - 1'b1;
  assign hit     = query < rd_x;

  // Table read address
  always_comb begin
    case (state)
      S_FIRST:   rd_addr = last_idx;
      S_SCAN_RD: rd_addr = k;
      S_FETCH_A: rd_addr = seg;
      S_FETCH_B: rd_addr = seg + 1'b1;
      default:   rd_addr = '0;
    endcase
  end

  plin_table #(
    .DEPTH (MAX_POINTS),
    .WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (in_ch.point_index),
    .wr_x    (in_ch.x_value),
    .wr_y    (in_ch.y_value),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // Magnitudes of the segment differences
  always_comb begin
    dy_mag   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    dq_mag   = dq[DW-1] ? DW'(-dq) : DW'(dq);
    dx_mag_c = dx[DW-1] ? DW'(-dx) : DW'(dx);
  end

  assign mul_start = (state == S_PREP) && (dx != '0);
  assign div_start = (state == S_MUL) && mul_stat.done;

  plin_mul #(
    .WIDTH (DW)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (dy_mag),
    .mplier_in (dq_mag),
    .product   (product),
    .status    (mul_stat)
  );

  plin_div #(
    .NUM_W (PW),
    .DEN_W (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (dx_mag),
    .quotient (quotient),
    .status   (div_stat)
  );

  // Quotient above 2^VW is clipped to 2^VW+1, which still saturates the sum
  assign quo_over = (|quotient[PW-1:VW+1]) || (quotient[VW] && (|quotient[VW-1:0]));

  // Final add and saturation
  always_comb begin
    yi_ext  = {{(RW-VW){yi[VW-1]}}, yi};
    quo_ext = {1'b0, quo};
    sum     = neg ? (yi_ext - quo_ext) : (yi_ext + quo_ext);
    sum_hi  = !sum[RW-1] && (sum[RW-2:VW-1] != '0);
    sum_lo  = sum[RW-1] && (sum[RW-2:VW-1] != {(RW-VW){1'b1}});
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= CW'(2);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept && (in_ch.operation == OP_EVAL)) begin
            state <= S_FIRST;
          end
        end
        S_FIRST:   state <= hit ? S_FETCH_A : S_LAST;
        S_LAST: begin
          if (!hit || (last_idx == IW'(1))) begin
            state <= S_FETCH_A;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (hit || (k == pen_idx)) begin
            state <= S_FETCH_A;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_FETCH_A: state <= S_FETCH_B;
        S_FETCH_B: state <= S_FETCH_C;
        S_FETCH_C: state <= S_PREP;
        S_PREP:    state <= (dx == '0) ? S_OUT : S_MUL;
        S_MUL: begin
          if (mul_stat.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP:   state <= S_SUM;
        S_SUM:     state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          query    <= in_ch.x_value;
          last_idx <= IW'(n_eff - 1'b1);
        end
      end
      S_FIRST: seg <= '0;
      S_LAST: begin
        seg <= pen_idx;
        k   <= IW'(1);
      end
      S_SCAN_CMP: begin
        seg <= hit ? (k - 1'b1) : k;
        k   <= k + 1'b1;
      end
      S_FETCH_B: begin
        xi <= rd_x;
        yi <= rd_y;
      end
      S_FETCH_C: begin
        dx <= {rd_x[VW-1], rd_x} - {xi[VW-1], xi};
        dy <= {rd_y[VW-1], rd_y} - {yi[VW-1], yi};
        dq <= {query[VW-1], query} - {xi[VW-1], xi};
      end
      S_PREP: begin
        dx_mag <= dx_mag_c;
        neg    <= dy[DW-1] ^ dq[DW-1] ^ dx[DW-1];
        if (dx == '0) begin
          res_val   <= yi;
          res_fault <= 1'b1;
          res_sat   <= 1'b0;
        end
      end
      S_CLAMP: quo <= quo_over ? QUO_SAT : quotient[QW-1:0];
      S_SUM: begin
        res_fault <= 1'b0;
        res_sat   <= sum_hi || sum_lo;
        if (sum_hi) begin
          res_val <= VAL_MAX;
        end else if (sum_lo) begin
          res_val <= VAL_MIN;
        end else begin
          res_val <= sum[VW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val   <= res_val;
      out_fault <= res_fault;
      out_sat   <= res_sat;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.interp_value = out_val;
  assign out_ch.divide_fault = out_fault;
  assign out_ch.saturated    = out_sat;

  // Checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (dx_mag != '0))
    else $error("divider started with zero divisor");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH_A) |-> (seg < last_idx))
    else $error("segment index past last breakpoint");

  a_fault_not_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_fault) |-> !out_sat)
    else $error("fault result flagged as saturated");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("result load did not present a beat");

endmodule
